// File: rtl/core/api_tx_request_framer_assert.svh
// Assertion macros shared by the framer checks.
// All of them sample on i_clk and are off while i_rst_n is low.
`ifndef API_TX_REQUEST_FRAMER_ASSERT_SVH
`define API_TX_REQUEST_FRAMER_ASSERT_SVH

// Same-cycle implication.
`define ATF_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("api_tx_request_framer: check failed");

// Next-cycle implication.
`define ATF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("api_tx_request_framer: check failed");

`endif

// File: rtl/core/atf_pkg.sv
package atf_pkg;

    // Line framing bytes
    localparam logic [7:0] START_DELIM   = 8'h7E;
    localparam logic [7:0] ESC_MARK      = 8'h7D;
    localparam logic [7:0] ESC_FLIP      = 8'h20;
    localparam logic [7:0] XON_CHAR      = 8'h11;
    localparam logic [7:0] XOFF_CHAR     = 8'h13;
    localparam logic [7:0] API_TX_REQ    = 8'h10;
    localparam logic [7:0] HDR_FIXED_LEN = 8'd14;
    localparam logic [7:0] CKSUM_BASE    = 8'hFF;
    localparam logic [7:0] MAX_PAYLOAD   = 8'd255;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ID  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_LONG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_NET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTIONS   = 3'd5;
    localparam int unsigned CFG_DATA_W = 64;

    typedef struct packed {
        logic [7:0]  frame_id;
        logic [63:0] dest_long_address;
        logic [15:0] dest_net_address;
        logic        short_addr_mode;
        logic [7:0]  hop_radius;
        logic [7:0]  tx_option_bits;
    } t_cfg;

    // One classified payload beat queued between front and back
    typedef struct packed {
        logic [7:0] pbyte;
        logic [7:0] cnt;    // clamped payload count, meaningful when first
        logic       first;  // opens a frame
        logic       last;   // closes a frame, checksum follows
    } t_entry;

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == START_DELIM) || (b == ESC_MARK) || (b == XON_CHAR) || (b == XOFF_CHAR);
    endfunction

endpackage

// File: rtl/core/atf_front.sv
module atf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tvalid,
    output logic               o_tready,
    input  logic [15:0]        i_tdata,
    input  logic               i_full,
    output logic               o_push,
    output atf_pkg::t_entry    o_entry
);

    logic [7:0] r_bytes_left;
    logic [7:0] n_bytes_left;
    logic [7:0] w_cnt;
    logic [7:0] w_left_after;
    logic       w_first;
    logic       w_accept;

    assign o_tready = !i_full;
    assign w_accept = i_tvalid && o_tready;
    assign w_first  = (r_bytes_left == 8'd0);

    // Clamp the count: zero means one, cap at the payload limit
    always_comb begin
        w_cnt = i_tdata[15:8];
        if (w_cnt == 8'd0) begin
            w_cnt = 8'd1;
        end else if (w_cnt > atf_pkg::MAX_PAYLOAD) begin
            w_cnt = atf_pkg::MAX_PAYLOAD;
        end
    end

    assign w_left_after = (w_first ? w_cnt : r_bytes_left) - 8'd1;

    always_comb begin
        n_bytes_left = r_bytes_left;
        if (w_accept) begin
            n_bytes_left = w_left_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 8'd0;
        end else begin
            r_bytes_left <= n_bytes_left;
        end
    end

    assign o_push        = w_accept;
    assign o_entry.pbyte = i_tdata[7:0];
    assign o_entry.cnt   = w_cnt;
    assign o_entry.first = w_first;
    assign o_entry.last  = (w_left_after == 8'd0);

endmodule

// File: rtl/core/atf_fifo.sv
module atf_fifo #(
    parameter int unsigned WIDTH = 18,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// File: rtl/core/atf_back.sv
module atf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  atf_pkg::t_cfg   i_cfg,
    input  atf_pkg::t_entry i_entry,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [7:0]      o_tdata,
    output logic            o_tlast,
    output logic            o_tuser
);

    // Raw byte positions of one frame
    localparam logic [4:0] IDX_START    = 5'd0;
    localparam logic [4:0] IDX_LEN_HI   = 5'd1;
    localparam logic [4:0] IDX_LEN_LO   = 5'd2;
    localparam logic [4:0] IDX_API      = 5'd3;
    localparam logic [4:0] IDX_FRAME_ID = 5'd4;
    localparam logic [4:0] IDX_ADDR0    = 5'd5;
    localparam logic [4:0] IDX_NET_HI   = 5'd13;
    localparam logic [4:0] IDX_NET_LO   = 5'd14;
    localparam logic [4:0] IDX_RADIUS   = 5'd15;
    localparam logic [4:0] IDX_OPTIONS  = 5'd16;
    localparam logic [4:0] IDX_PAYLOAD  = 5'd17;
    localparam logic [4:0] IDX_CKSUM    = 5'd18;

    atf_pkg::t_entry r_ent;
    atf_pkg::t_entry n_ent;
    logic            r_busy,   n_busy;
    logic [4:0]      r_idx,    n_idx;
    logic            r_half,   n_half;
    logic [7:0]      r_sum,    n_sum;
    logic            r_ovalid, n_ovalid;
    logic [7:0]      r_odata,  n_odata;
    logic            r_olast,  n_olast;
    logic            r_ouser,  n_ouser;

    logic [7:0] w_raw;
    logic [8:0] w_len;
    logic [2:0] w_addr_k;
    logic [7:0] w_addr_byte;
    logic       w_need_esc;
    logic       w_advance;
    logic       w_step_done;
    logic       w_ent_done;
    logic       w_is_data;

    assign w_len    = 9'(atf_pkg::HDR_FIXED_LEN) + 9'(r_ent.cnt);
    assign w_addr_k = 3'(r_idx - IDX_ADDR0);

    // Destination bytes, most significant first; short mode zeroes all but two
    always_comb begin
        case (w_addr_k)
            3'd0:    w_addr_byte = i_cfg.dest_long_address[63:56];
            3'd1:    w_addr_byte = i_cfg.dest_long_address[55:48];
            3'd2:    w_addr_byte = i_cfg.dest_long_address[47:40];
            3'd3:    w_addr_byte = i_cfg.dest_long_address[39:32];
            3'd4:    w_addr_byte = i_cfg.dest_long_address[31:24];
            3'd5:    w_addr_byte = i_cfg.dest_long_address[23:16];
            3'd6:    w_addr_byte = i_cfg.dest_long_address[15:8];
            default: w_addr_byte = i_cfg.dest_long_address[7:0];
        endcase
        if (i_cfg.short_addr_mode && (w_addr_k >= 3'd2)) begin
            w_addr_byte = 8'd0;
        end
    end

    always_comb begin
        case (r_idx)
            IDX_START:    w_raw = atf_pkg::START_DELIM;
            IDX_LEN_HI:   w_raw = {7'd0, w_len[8]};
            IDX_LEN_LO:   w_raw = w_len[7:0];
            IDX_API:      w_raw = atf_pkg::API_TX_REQ;
            IDX_FRAME_ID: w_raw = i_cfg.frame_id;
            IDX_NET_HI:   w_raw = i_cfg.dest_net_address[15:8];
            IDX_NET_LO:   w_raw = i_cfg.dest_net_address[7:0];
            IDX_RADIUS:   w_raw = i_cfg.hop_radius;
            IDX_OPTIONS:  w_raw = i_cfg.tx_option_bits;
            IDX_PAYLOAD:  w_raw = r_ent.pbyte;
            IDX_CKSUM:    w_raw = atf_pkg::CKSUM_BASE - r_sum;
            default:      w_raw = w_addr_byte;
        endcase
    end

    assign w_need_esc  = atf_pkg::needs_escape(w_raw) && (r_idx != IDX_START);
    assign w_advance   = r_busy && (!r_ovalid || i_tready);
    assign w_step_done = !w_need_esc || r_half;
    assign w_ent_done  = w_step_done &&
                         ((r_idx == IDX_CKSUM) || ((r_idx == IDX_PAYLOAD) && !r_ent.last));
    assign w_is_data   = (r_idx >= IDX_API) && (r_idx <= IDX_PAYLOAD);
    assign o_pop       = (!r_busy || (w_advance && w_ent_done)) && !i_empty;

    always_comb begin
        n_ent    = r_ent;
        n_busy   = r_busy;
        n_idx    = r_idx;
        n_half   = r_half;
        n_sum    = r_sum;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_olast  = r_olast;
        n_ouser  = r_ouser;
        if (w_advance) begin
            n_ovalid = 1'b1;
            n_odata  = w_need_esc ? (r_half ? (w_raw ^ atf_pkg::ESC_FLIP) : atf_pkg::ESC_MARK)
                                  : w_raw;
            n_olast  = w_ent_done;
            n_ouser  = w_ent_done && (r_idx == IDX_CKSUM);
            n_half   = w_need_esc && !r_half;
            if (w_step_done) begin
                if (w_is_data) begin
                    n_sum = ((r_idx == IDX_API) ? 8'd0 : r_sum) + w_raw;
                end
                n_idx = r_idx + 5'd1;
            end
            if (w_ent_done) begin
                n_busy = 1'b0;
            end
        end else if (i_tready) begin
            n_ovalid = 1'b0;
        end
        if (o_pop) begin
            n_ent  = i_entry;
            n_busy = 1'b1;
            n_idx  = i_entry.first ? IDX_START : IDX_PAYLOAD;
            n_half = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= IDX_START;
            r_half   <= 1'b0;
            r_sum    <= 8'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_idx    <= n_idx;
            r_half   <= n_half;
            r_sum    <= n_sum;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent   <= n_ent;
        r_odata <= n_odata;
        r_olast <= n_olast;
        r_ouser <= n_ouser;
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tlast  = r_olast;
    assign o_tuser  = r_ouser;

endmodule

// File: rtl/core/api_tx_request_framer.sv
// An accepted beat passes queue memory, entry register and output register to the line.
// Throughput: one line byte per cycle from the back-end sequencer while the line is
// ready; a payload beat yields its byte, escaped where needed, plus the checksum on the
// closing beat; the beat that opens a frame also yields delimiter, length and header.
// Reset (i_rst_n low, synchronous): queue, sequencer and frame state clear; the
// configuration registers return to their documented defaults.
module api_tx_request_framer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port
    input  logic                               i_cfg_we,
    input  logic [atf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [atf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Payload beats in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [15:0]                        s_axis_tdata,  // [7:0] payload_byte, [15:8] payload_count
    // Escaped line bytes out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,  // [7:0] line_byte
    output logic                               m_axis_tlast,  // run_end: last byte caused by the input beat
    output logic                               m_axis_tuser   // [0] frame_end: last byte of the checksum
);

    // Configuration registers. Writes must arrive only while the framer is idle; the block
    // does not enforce this. The back end reads them live while it builds each header.
    atf_pkg::t_cfg r_cfg;
    atf_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                atf_pkg::CFG_FRAME_ID:  n_cfg.frame_id          = i_cfg_data[7:0];
                atf_pkg::CFG_DEST_LONG: n_cfg.dest_long_address = i_cfg_data;
                atf_pkg::CFG_DEST_NET:  n_cfg.dest_net_address  = i_cfg_data[15:0];
                atf_pkg::CFG_SHORT:     n_cfg.short_addr_mode   = i_cfg_data[0];
                atf_pkg::CFG_RADIUS:    n_cfg.hop_radius        = i_cfg_data[7:0];
                atf_pkg::CFG_OPTIONS:   n_cfg.tx_option_bits    = i_cfg_data[7:0];
                default:                n_cfg = r_cfg;  // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_id          <= 8'd1;
            r_cfg.dest_long_address <= 64'd0;
            r_cfg.dest_net_address  <= 16'hFFFE;
            r_cfg.short_addr_mode   <= 1'b0;
            r_cfg.hop_radius        <= 8'd0;
            r_cfg.tx_option_bits    <= 8'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front end: accept a beat, track the bytes left in the frame and mark the
    // beats that open and close a frame.
    atf_pkg::t_entry                  w_push_entry;
    logic                             w_push;
    logic                             w_full;
    logic                             w_empty;
    logic                             w_pop;
    logic [$bits(atf_pkg::t_entry)-1:0] w_pop_data;

    atf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    // Short queue: lets the front keep taking beats while the back is still
    // expanding a header or waiting on the line.
    atf_fifo #(
        .WIDTH ($bits(atf_pkg::t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_entry),
        .i_pop   (w_pop),
        .o_rdata (w_pop_data),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Back end: walk delimiter, length, header, payload and checksum one raw byte
    // at a time, escape each as a mark byte then the flipped byte where needed, and hold
    // the result in the output register until the line takes it.
    atf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_entry  (atf_pkg::t_entry'(w_pop_data)),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

endmodule

// File: rtl/core/atf_checker.sv
`include "api_tx_request_framer_assert.svh"

module atf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_tvalid,
    input logic       i_tready,
    input logic [7:0] i_tdata,
    input logic       i_tlast,
    input logic       i_tuser
);

    logic r_in_frame;
    logic w_beat;

    assign w_beat = i_tvalid && i_tready;

    // Open at a start delimiter, close after the checksum beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
        end else if (w_beat) begin
            r_in_frame <= !i_tuser;
        end
    end

    `ATF_ASSERT_NEXT(a_out_hold, i_tvalid && !i_tready, i_tvalid && $stable(i_tdata) && $stable(i_tlast) && $stable(i_tuser))
    `ATF_ASSERT_IMPLY(a_delim_only_at_start, w_beat, (i_tdata == atf_pkg::START_DELIM) == !r_in_frame)
    `ATF_ASSERT_IMPLY(a_escape_not_last, i_tvalid && (i_tdata == atf_pkg::ESC_MARK), !i_tlast)
    `ATF_ASSERT_IMPLY(a_frame_end_is_run_end, i_tvalid && i_tuser, i_tlast)

endmodule

bind api_tx_request_framer atf_checker u_atf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_tvalid (m_axis_tvalid),
    .i_tready (m_axis_tready),
    .i_tdata  (m_axis_tdata),
    .i_tlast  (m_axis_tlast),
    .i_tuser  (m_axis_tuser)
);

// File: dv/tb.sv
module tb;

    // Indexes past the last register; writes to them must change nothing
    localparam logic [atf_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [atf_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned HOLD_AFTER    = 10;   // big-frame beats before the long sink hold-off
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned RANDOM_PHASES = 4;
    localparam int unsigned PHASE_ITEMS   = 18;
    localparam int unsigned BIG_BEATS     = 50;

    // One expected beat on the line side
    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_end;
        logic       frame_end;
    } t_line_beat;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_QUARTER, SINK_MOSTLY} t_sink_mode;

    // Tracks register and frame state of the framer and queues the escaped
    // line bytes that each accepted payload beat must produce.
    class line_byte_tracker;
        atf_pkg::t_cfg regs;
        logic [7:0]    bytes_left;
        logic [7:0]    frame_sum;
        t_line_beat    line_bytes_due[$];
        int unsigned   errors;
        int unsigned   beats_in;

        function new();
            regs.frame_id          = 8'd1;
            regs.dest_long_address = 64'd0;
            regs.dest_net_address  = 16'hFFFE;
            regs.short_addr_mode   = 1'b0;
            regs.hop_radius        = 8'd0;
            regs.tx_option_bits    = 8'd0;
            bytes_left = 8'd0;
            frame_sum  = 8'd0;
            errors     = 0;
            beats_in   = 0;
        endfunction

        function void apply_reg(logic [atf_pkg::CFG_IDX_W-1:0] idx,
                                logic [atf_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                atf_pkg::CFG_FRAME_ID:  regs.frame_id          = val[7:0];
                atf_pkg::CFG_DEST_LONG: regs.dest_long_address = val;
                atf_pkg::CFG_DEST_NET:  regs.dest_net_address  = val[15:0];
                atf_pkg::CFG_SHORT:     regs.short_addr_mode   = val[0];
                atf_pkg::CFG_RADIUS:    regs.hop_radius        = val[7:0];
                atf_pkg::CFG_OPTIONS:   regs.tx_option_bits    = val[7:0];
                default: ;
            endcase
        endfunction

        function void push_raw(logic [7:0] b);
            t_line_beat t;
            t.line_byte = b;
            t.run_end   = 1'b0;
            t.frame_end = 1'b0;
            line_bytes_due.push_back(t);
        endfunction

        function void push_escaped(logic [7:0] b);
            if (b == atf_pkg::START_DELIM || b == atf_pkg::ESC_MARK ||
                b == atf_pkg::XON_CHAR || b == atf_pkg::XOFF_CHAR) begin
                push_raw(atf_pkg::ESC_MARK);
                push_raw(b ^ atf_pkg::ESC_FLIP);
            end else begin
                push_raw(b);
            end
        endfunction

        function void push_summed(logic [7:0] b);
            frame_sum = frame_sum + b;
            push_escaped(b);
        endfunction

        function void note_beat(logic [7:0] pbyte, logic [7:0] count);
            logic [7:0]  n;
            logic [7:0]  ab;
            logic [15:0] len;
            t_line_beat  t;
            int          k;
            beats_in++;
            if (bytes_left == 0) begin
                // Zero count opens a one-byte frame; saturate at the payload limit
                n = (count == 8'd0) ? 8'd1 : count;
                if (n > atf_pkg::MAX_PAYLOAD) n = atf_pkg::MAX_PAYLOAD;
                bytes_left = n;
                frame_sum  = 8'd0;
                len = {8'd0, atf_pkg::HDR_FIXED_LEN} + {8'd0, n};
                push_raw(atf_pkg::START_DELIM);
                push_escaped(len[15:8]);
                push_escaped(len[7:0]);
                push_summed(atf_pkg::API_TX_REQ);
                push_summed(regs.frame_id);
                for (k = 0; k < 8; k++) begin
                    ab = 8'(regs.dest_long_address >> (56 - 8 * k));
                    if (regs.short_addr_mode && k >= 2) ab = 8'd0;
                    push_summed(ab);
                end
                push_summed(regs.dest_net_address[15:8]);
                push_summed(regs.dest_net_address[7:0]);
                push_summed(regs.hop_radius);
                push_summed(regs.tx_option_bits);
            end
            push_summed(pbyte);
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 0) begin
                push_escaped(atf_pkg::CKSUM_BASE - frame_sum);
                t = line_bytes_due.pop_back();
                t.frame_end = 1'b1;
                line_bytes_due.push_back(t);
                frame_sum = 8'd0;
            end
            t = line_bytes_due.pop_back();
            t.run_end = 1'b1;
            line_bytes_due.push_back(t);
        endfunction

        task report(string what, logic [7:0] got, logic [7:0] want);
            $display("[%0t] mismatch on %s: got %02h, expected %02h", $time, what, got, want);
            errors++;
        endtask

        task match_line_byte(logic [7:0] d, logic l, logic u);
            t_line_beat w;
            if (line_bytes_due.size() == 0) begin
                report("line byte with nothing due", d, 8'h00);
            end else begin
                w = line_bytes_due.pop_front();
                if (d !== w.line_byte) report("line_byte", d, w.line_byte);
                if (l !== w.run_end)   report("run_end", {7'd0, l}, {7'd0, w.run_end});
                if (u !== w.frame_end) report("frame_end", {7'd0, u}, {7'd0, w.frame_end});
            end
        endtask
    endclass

    // Block ports; every input starts from a known value
    logic                           i_clk;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [atf_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [atf_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [15:0]                    s_axis_tdata  = '0;  // [7:0] payload_byte, [15:8] payload_count
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [7:0]                     m_axis_tdata;        // [7:0] line_byte
    logic                           m_axis_tlast;        // run_end
    logic                           m_axis_tuser;        // [0] frame_end

    line_byte_tracker tracker = new();

    // Bytes that the line escapes; used to aim payload and checksum at them
    logic [7:0] esc_set [4] = '{atf_pkg::START_DELIM, atf_pkg::ESC_MARK,
                                atf_pkg::XON_CHAR, atf_pkg::XOFF_CHAR};

    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;
    bit          hold_req = 1'b0;

    api_tx_request_framer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the stream hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Line sink: check every accepted beat, then pick tready for the next edge.
    // The stall pattern is redrawn at random from four modes; once, when the stimulus
    // asks, hold tready low for a long stretch so the block backs up.
    initial begin : line_sink
        int unsigned hold_left;
        int unsigned sink_cycle;
        bit          hold_done;
        t_sink_mode  sink_mode;
        hold_left  = 0;
        sink_cycle = 0;
        hold_done  = 1'b0;
        sink_mode  = SINK_OPEN;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                tracker.match_line_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (!hold_done && hold_req) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            sink_cycle++;
            if (sink_cycle % 64 == 0) sink_mode = t_sink_mode'($urandom_range(0, 3));
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (sink_mode)
                    SINK_OPEN:    m_axis_tready <= 1'b1;
                    SINK_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
                    SINK_QUARTER: m_axis_tready <= (sink_cycle % 4 == 0);
                    default:      m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Offer one payload beat and hold it until accepted. Between bursts of
    // random length drop tvalid for a random gap.
    task automatic send_beat(input logic [7:0] pbyte, input logic [7:0] count);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {count, pbyte};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.note_beat(pbyte, count);
    endtask

    // Stop offering and wait for every due line byte
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.line_bytes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [atf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [atf_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.apply_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Drain, then load all six registers
    task automatic load_regs(input logic [7:0] fid, input logic [63:0] long_addr,
                             input logic [15:0] net_addr, input logic short_mode,
                             input logic [7:0] radius, input logic [7:0] opts);
        drain();
        write_reg(atf_pkg::CFG_FRAME_ID, {56'd0, fid});
        write_reg(atf_pkg::CFG_DEST_LONG, long_addr);
        write_reg(atf_pkg::CFG_DEST_NET, {48'd0, net_addr});
        write_reg(atf_pkg::CFG_SHORT, {63'd0, short_mode});
        write_reg(atf_pkg::CFG_RADIUS, {56'd0, radius});
        write_reg(atf_pkg::CFG_OPTIONS, {56'd0, opts});
    endtask

    // Random payload byte, leaning toward the escaped values
    function automatic logic [7:0] pick_payload();
        if ($urandom_range(0, 3) == 0) return esc_set[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Send a whole frame; the count rides only on the first beat, later beats
    // carry noise there. Optionally aim the last byte so the checksum escapes.
    task automatic offer_frame(input logic [7:0] count, input bit aim_cksum);
        logic [7:0] n;
        logic [7:0] pbyte;
        int         i;
        n = (count == 8'd0) ? 8'd1 : count;
        for (i = 0; i < n; i++) begin
            pbyte = pick_payload();
            if (aim_cksum && n >= 2 && i == n - 1)
                pbyte = atf_pkg::CKSUM_BASE - esc_set[$urandom_range(0, 3)] - tracker.frame_sum;
            send_beat(pbyte, (i == 0) ? count : 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int unsigned p;
        int unsigned phase_start;
        int unsigned beat_no;
        logic [7:0]  count;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: shortest frame, then a zero count acting as one
        send_beat(8'h00, 8'd1);
        send_beat(8'hFF, 8'd0);

        // Length low byte 0x11 escapes; change the frame id mid-frame, which
        // must only show up in the next frame
        send_beat(atf_pkg::START_DELIM, 8'd3);
        drain();
        write_reg(atf_pkg::CFG_FRAME_ID, 64'(atf_pkg::START_DELIM));
        send_beat(atf_pkg::ESC_MARK, 8'($urandom_range(0, 255)));
        send_beat(atf_pkg::XON_CHAR, 8'($urandom_range(0, 255)));

        // Length low byte 0x13; close with a checksum of 0x7E
        send_beat(atf_pkg::XOFF_CHAR, 8'd5);
        send_beat(8'h80, 8'd0);
        send_beat(8'h01, 8'hFF);
        send_beat(8'h7F, 8'd5);
        send_beat(atf_pkg::CKSUM_BASE - atf_pkg::START_DELIM - tracker.frame_sum, 8'd0);

        // Writes to unused indexes are dropped
        drain();
        write_reg(CFG_SPARE_LO, {$urandom, $urandom});
        write_reg(CFG_SPARE_HI, '1);
        offer_frame(8'd2, 1'b0);

        // Register extremes, short address mode both ways
        load_regs(8'hFF, '1, 16'hFFFF, 1'b1, 8'hFF, 8'hFF);
        offer_frame(8'd2, 1'b1);
        load_regs(8'hFF, '1, 16'hFFFF, 1'b0, 8'hFF, 8'hFF);
        offer_frame(8'd2, 1'b0);
        load_regs(8'h00, '0, 16'h0000, 1'b0, 8'h00, 8'h00);
        offer_frame(8'd1, 1'b0);

        // Configured header bytes that all need escaping
        load_regs(atf_pkg::XON_CHAR, 64'h7E7D_1113_7E7D_1113, 16'h7D7E, 1'b0,
                  atf_pkg::XOFF_CHAR, atf_pkg::START_DELIM);
        offer_frame(8'd2, 1'b0);

        // Random phases: fresh registers, then mostly short frames
        for (p = 0; p < RANDOM_PHASES; p++) begin
            load_regs(8'($urandom), {$urandom, $urandom}, 16'($urandom), 1'($urandom),
                      8'($urandom), 8'($urandom));
            phase_start = tracker.beats_in;
            while (tracker.beats_in - phase_start < PHASE_ITEMS) begin
                case ($urandom_range(0, 15))
                    0:       count = 8'd0;
                    1, 2, 3: count = 8'($urandom_range(7, 30));
                    default: count = 8'($urandom_range(1, 6));
                endcase
                offer_frame(count, $urandom_range(0, 2) == 0);
            end
        end

        // Open the largest frame, whose length high byte is 0x01, and run part
        // of it; the long sink hold-off lands inside while beats keep coming
        load_regs(8'($urandom), {$urandom, $urandom}, 16'($urandom), 1'($urandom),
                  8'($urandom), 8'($urandom));
        for (beat_no = 0; beat_no < BIG_BEATS; beat_no++) begin
            if (beat_no == HOLD_AFTER) hold_req = 1'b1;
            send_beat(pick_payload(),
                      (beat_no == 0) ? atf_pkg::MAX_PAYLOAD : 8'($urandom_range(0, 255)));
        end

        // Wait for the tail, then give stray bytes a chance to show up
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
